// ===== sv/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Paged bitmap block allocator package
// Shared types, codes and field widths for the allocator and its parts.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int OPCODE_W = 1;
  localparam int PAGE_W   = 4;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 26;
  localparam int COUNT_W  = 11;
  localparam int SIZE_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd64;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FREE,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

// ===== sv/paged_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Paged bitmap block allocator
// Hands out and releases fixed-size blocks tracked in a paged used map.
// ----------------------------------------------------------------------------
// The input channel takes one request per transfer: an allocate carries a
// start page, a free carries a slot index. Each request gives exactly one
// result transfer with a status, a slot index and a byte offset.
// The used map is held in a RAM with one row per page. A small sequencer
// reduces the start page by repeated subtraction, then reads one page per
// cycle and runs the lowest-free search on it, then forms the byte offset
// with a single multiplier.
// An allocate makes R subtractions to reduce the start page (R from 0 to
// 15), then reads P pages (P from 1 to the page count, 16 by default),
// then takes the multiply and output steps. A free takes the free, multiply
// and output steps; a refused request goes straight to the multiply step.
// The next request is taken on the cycle after the result is loaded.
// Reset clears the sequencer and a valid bit per page row, so the whole map
// reads as free at once; the registers return to 1024 blocks of 64 bytes.
// While the receiver stalls, the result is held in the output register and
// the next request is still accepted and worked on; only loading its result
// waits until the register is free.
// ----------------------------------------------------------------------------
module paged_bitmap_block_allocator
  import pba_pkg::*;
#(
  parameter int MAX_SLOTS  = 1024,
  parameter int PAGE_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [PAGE_W-1:0]     in_start_page,
  input  logic [SLOT_W-1:0]     in_free_slot,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NPAGES = (MAX_SLOTS + PAGE_SLOTS - 1) / PAGE_SLOTS;
  localparam int PA_W   = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam int PNW    = PA_W + 1;
  localparam int MDW    = (PNW > PAGE_W) ? PNW : PAGE_W;
  localparam int PG_SH  = $clog2(PAGE_SLOTS);
  localparam int IW     = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    blk_count_r;
  logic [SIZE_W-1:0]     blk_size_r;
  logic [MDW-1:0]        page_r, page_nxt;
  logic [PNW-1:0]        visit_r, visit_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  logic [SLOT_W-1:0]     echo_r, echo_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [OFFSET_W-1:0]   prod_r, prod_nxt;
  logic [NPAGES-1:0]     row_vld_r;
  logic                  rvld_q_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [OFFSET_W-1:0]   out_offset_r;

  logic [CW-1:0]         eff_cnt;
  logic [CW:0]           pages_w;
  logic [PNW-1:0]        pages;
  logic [PA_W-1:0]       cur_pg;
  logic [PA_W-1:0]       next_pg;
  logic [CW:0]           lim;
  logic [PAGE_SLOTS-1:0] avail;
  logic [PAGE_SLOTS-1:0] row;
  logic                  found;
  logic [PAGE_SLOTS-1:0] onehot;
  logic [PG_SH-1:0]      idx;
  logic [IW-1:0]         cand;
  logic [PA_W-1:0]       free_row;
  logic                  mod_done;
  logic                  scan_last;
  logic                  out_load;
  logic                  in_range;
  logic [31:0]           product;

  logic                  ram_we;
  logic [PA_W-1:0]       ram_waddr;
  logic [PAGE_SLOTS-1:0] ram_wdata;
  logic [PA_W-1:0]       ram_raddr;
  logic [PAGE_SLOTS-1:0] ram_rdata;

  assign eff_cnt = (CW'(blk_count_r) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(blk_count_r);
  assign pages_w = ((CW + 1)'(eff_cnt) + (CW + 1)'(PAGE_SLOTS - 1)) >> PG_SH;
  assign pages   = PNW'(pages_w);
  assign cur_pg  = page_r[PA_W-1:0];
  assign next_pg = ((PNW'(cur_pg) + PNW'(1)) == pages) ? '0 : cur_pg + PA_W'(1);
  assign lim     = (CW + 1)'(eff_cnt) - ((CW + 1)'(cur_pg) << PG_SH);
  assign row     = rvld_q_r ? ram_rdata : '0;
  assign cand    = (IW'(cur_pg) << PG_SH) | IW'(idx);
  assign free_row = PA_W'(slot_r >> PG_SH);

  assign mod_done  = page_r < MDW'(pages);
  assign scan_last = visit_r == pages;
  assign out_load  = !out_valid_r || !out_stall;
  assign in_range  = CW'(in_free_slot) < eff_cnt;
  assign product   = 32'(slot_r) * 32'(blk_size_r);

  always_comb begin
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      avail[i] = (CW + 1)'(i) < lim;
    end
  end

  pba_find #(
    .WIDTH (PAGE_SLOTS)
  ) u_find (
    .row    (row),
    .avail  (avail),
    .found  (found),
    .onehot (onehot),
    .idx    (idx)
  );

  pba_ram #(
    .WIDTH (PAGE_SLOTS),
    .DEPTH (NPAGES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_ALLOC) begin
            state_nxt = (eff_cnt == '0) ? ST_MUL : ST_MOD;
          end else begin
            state_nxt = in_range ? ST_FREE : ST_MUL;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found || scan_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_FREE: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    page_nxt   = page_r;
    visit_nxt  = visit_r;
    slot_nxt   = slot_r;
    echo_nxt   = echo_r;
    status_nxt = status_r;
    prod_nxt   = prod_r;
    ram_we     = 1'b0;
    ram_waddr  = cur_pg;
    ram_wdata  = row | onehot;
    ram_raddr  = PA_W'(in_free_slot >> PG_SH);
    unique case (state_r)
      ST_IDLE: begin
        page_nxt = MDW'(in_start_page);
        slot_nxt = IW'(in_free_slot);
        echo_nxt = in_free_slot;
        if (in_opcode == OP_ALLOC) begin
          slot_nxt   = '0;
          echo_nxt   = '0;
          status_nxt = (eff_cnt == '0) ? STAT_FULL : STAT_OK;
        end else begin
          status_nxt = in_range ? STAT_OK : STAT_RANGE;
        end
      end
      ST_MOD: begin
        ram_raddr = cur_pg;
        if (mod_done) begin
          visit_nxt = PNW'(1);
        end else begin
          page_nxt = page_r - MDW'(pages);
        end
      end
      ST_SCAN: begin
        ram_raddr = next_pg;
        if (found) begin
          ram_we     = 1'b1;
          slot_nxt   = cand;
          echo_nxt   = SLOT_W'(32'(cand));
          status_nxt = STAT_OK;
        end else if (scan_last) begin
          slot_nxt   = '0;
          echo_nxt   = '0;
          status_nxt = STAT_FULL;
        end else begin
          page_nxt  = MDW'(next_pg);
          visit_nxt = visit_r + PNW'(1);
        end
      end
      ST_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = free_row;
        ram_wdata = row & ~(PAGE_SLOTS'(1) << slot_r[PG_SH-1:0]);
      end
      ST_MUL: begin
        prod_nxt = product[OFFSET_W-1:0];
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blk_count_r <= COUNT_RESET;
      blk_size_r  <= SIZE_RESET;
      row_vld_r   <= '0;
      rvld_q_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvld_q_r <= row_vld_r[ram_raddr];
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_COUNT) begin
          blk_count_r <= cfg_wdata[COUNT_W-1:0];
        end else begin
          blk_size_r <= cfg_wdata[SIZE_W-1:0];
        end
      end
      if (state_r == ST_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    visit_r  <= visit_nxt;
    slot_r   <= slot_nxt;
    echo_r   <= echo_nxt;
    status_r <= status_nxt;
    prod_r   <= prod_nxt;
    if (state_r == ST_OUT && out_load) begin
      out_status_r <= status_r;
      out_slot_r   <= echo_r;
      out_offset_r <= (status_r == STAT_OK) ? prod_r : '0;
    end
  end

  assign in_stall        = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_byte_offset = out_offset_r;

  a_map_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SCAN || state_r == ST_FREE))
    else $error("used map written outside a scan or free step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && found) |-> ((CW + 1)'(cand) < (CW + 1)'(eff_cnt)))
    else $error("allocated slot at or above the block count");

  a_scan_visits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (visit_r != '0 && visit_r <= pages))
    else $error("page visit count out of bounds");

  a_written_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> row_vld_r[$past(ram_waddr)])
    else $error("written map row not marked valid");

endmodule

// ===== sv/pba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pba_find.sv =====
// ----------------------------------------------------------------------------
// Lowest free slot finder
// Picks the lowest slot of one page that is both free and available.
// ----------------------------------------------------------------------------
module pba_find #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         row,
  input  logic [WIDTH-1:0]         avail,
  output logic                     found,
  output logic [WIDTH-1:0]         onehot,
  output logic [$clog2(WIDTH)-1:0] idx
);

  localparam int IW = $clog2(WIDTH);

  logic [WIDTH-1:0] free_vec;

  assign free_vec = ~row & avail;
  assign found    = |free_vec;
  assign onehot   = free_vec & (~free_vec + WIDTH'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the paged bitmap block allocator
// A table of directed requests and register writes is run first. Then random
// phases follow, each with its own block count and block size. A local
// booking model keeps its own used map, predicts every result, and each
// result transfer is compared field by field. Both sides idle at random, and
// one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  localparam int MAP_SLOTS       = 1024;
  localparam int SLOTS_PER_PAGE  = 64;
  localparam int N_DIR           = 29;
  localparam int N_PHASES        = 20;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_HOLD       = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offs;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [OPCODE_W-1:0]   op;
    logic [PAGE_W-1:0]     page;
    logic [SLOT_W-1:0]     slot;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    alloc_result_t         want;
  } dir_row_t;

  localparam alloc_result_t NO_RESULT = '0;

  // Columns: kind, opcode, start page, free slot, register, write data, result.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_KNOWN, OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd0, 26'd0}},
    '{ROW_KNOWN, OP_ALLOC, 4'd15, 10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd960, 26'd61440}},
    '{ROW_KNOWN, OP_ALLOC, 4'd15, 10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd961, 26'd61504}},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd1023, REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd1023, 26'd65472}},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd961,  REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd961, 26'd61504}},
    '{ROW_PRED,  OP_ALLOC, 4'd3,  10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd100,  NO_RESULT},
    '{ROW_PRED,  OP_ALLOC, 4'd7,  10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd960,  REG_BLOCK_COUNT, 16'd0,
      '{STAT_RANGE, 10'd960, 26'd0}},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd100,  REG_BLOCK_COUNT, 16'd0,
      '{STAT_RANGE, 10'd100, 26'd0}},
    '{ROW_PRED,  OP_FREE,  4'd0,  10'd99,   REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_KNOWN, OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_FULL, 10'd0, 26'd0}},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_RANGE, 10'd0, 26'd0}},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd1,    NO_RESULT},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd0, 26'd0}},
    '{ROW_PRED,  OP_ALLOC, 4'd9,  10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_KNOWN, OP_ALLOC, 4'd5,  10'd0,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_FULL, 10'd0, 26'd0}},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'hF7FF, NO_RESULT},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_SIZE,  16'd0,    NO_RESULT},
    '{ROW_PRED,  OP_ALLOC, 4'd15, 10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_SIZE,  16'hFFFF, NO_RESULT},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd1023, REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd1023, 26'd67042305}},
    '{ROW_PRED,  OP_ALLOC, 4'd15, 10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_SIZE,  16'd1,    NO_RESULT},
    '{ROW_KNOWN, OP_FREE,  4'd0,  10'd1,    REG_BLOCK_COUNT, 16'd0,
      '{STAT_OK, 10'd1, 26'd1}},
    '{ROW_CFG,   OP_ALLOC, 4'd0,  10'd0,    REG_BLOCK_COUNT, 16'd65,   NO_RESULT},
    '{ROW_PRED,  OP_ALLOC, 4'd1,  10'd0,    REG_BLOCK_COUNT, 16'd0,    NO_RESULT},
    '{ROW_PRED,  OP_FREE,  4'd0,  10'd1023, REG_BLOCK_COUNT, 16'd0,    NO_RESULT}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [PAGE_W-1:0]     in_start_page;
  logic [SLOT_W-1:0]     in_free_slot;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_W-1:0]     out_slot;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit                    slot_used [MAP_SLOTS];
  logic [COUNT_W-1:0]    model_count;
  logic [SIZE_W-1:0]     model_size;
  alloc_result_t         pending_q [$];
  int                    errors;
  int                    n_alloc_ok, n_full, n_free_ok, n_range, n_settings;
  int                    hold_req;
  bit                    calm;
  bit                    burst;

  paged_bitmap_block_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_start_page   (in_start_page),
    .in_free_slot    (in_free_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_byte_offset (out_byte_offset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[paged_bitmap_block_allocator] ERROR");
    $finish;
  end

  function automatic int unsigned usable_slots();
    return (model_count > MAP_SLOTS) ? MAP_SLOTS : model_count;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Books one request against the local used map and returns its answer.
  function automatic alloc_result_t book_request(input logic [OPCODE_W-1:0] op,
                                                 input logic [PAGE_W-1:0] page,
                                                 input logic [SLOT_W-1:0] slot);
    alloc_result_t r;
    int unsigned   lim, pages, pg, first, last;
    r = '0;
    lim = usable_slots();
    if (op == OP_ALLOC) begin
      r.status = STAT_FULL;
      if (lim != 0) begin
        pages = (lim + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
        pg = page % pages;
        for (int p = 0; p < pages && r.status != STAT_OK; p++) begin
          first = pg * SLOTS_PER_PAGE;
          last = (first + SLOTS_PER_PAGE > lim) ? lim : first + SLOTS_PER_PAGE;
          for (int unsigned s = first; s < last && r.status != STAT_OK; s++) begin
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              r.status = STAT_OK;
              r.slot = SLOT_W'(s);
              r.offs = OFFSET_W'(s * model_size);
            end
          end
          pg = (pg + 1 == pages) ? 0 : pg + 1;
        end
      end
    end else begin
      r.slot = slot;
      if (slot >= lim) begin
        r.status = STAT_RANGE;
      end else begin
        slot_used[slot] = 1'b0;
        r.status = STAT_OK;
        r.offs = OFFSET_W'(32'(slot) * 32'(model_size));
      end
    end
    return r;
  endfunction

  task automatic offer(input logic [OPCODE_W-1:0] op, input logic [PAGE_W-1:0] page,
                       input logic [SLOT_W-1:0] slot, input bit known,
                       input alloc_result_t want);
    alloc_result_t pred;
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_start_page <= page;
    in_free_slot  <= slot;
    do @(posedge clk); while (in_stall);
    pred = book_request(op, page, slot);
    pending_q.push_back(known ? want : pred);
    if (pred.status == STAT_FULL) n_full++;
    else if (pred.status == STAT_RANGE) n_range++;
    else if (op == OP_ALLOC) n_alloc_ok++;
    else n_free_ok++;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLOCK_COUNT) model_count = data[COUNT_W-1:0];
    else model_size = data[SIZE_W-1:0];
    n_settings++;
  endtask

  // Result side: random stalls, a quiet mode, and a long hold on request.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (1 + $urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer: status %0d slot %0d offset %0d",
                 $time, out_status, out_slot, out_byte_offset);
      end else begin
        want = pending_q.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_status);
        end
        if (out_slot !== want.slot) begin
          errors++;
          $display("%0t: slot mismatch: expected %0d, got %0d",
                   $time, want.slot, out_slot);
        end
        if (out_byte_offset !== want.offs) begin
          errors++;
          $display("%0t: byte offset mismatch: expected %0d, got %0d",
                   $time, want.offs, out_byte_offset);
        end
      end
    end
  end

  initial begin
    logic [OPCODE_W-1:0]            op;
    logic [SLOT_W-1:0]              slot;
    logic [COUNT_W-1:0]             new_count;
    logic [SIZE_W-1:0]              new_size;
    logic [CFG_DATA_W-COUNT_W-1:0]  junk;
    int unsigned                    lim, from, pick;
    int                             alloc_pct;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_ALLOC;
    in_start_page = '0;
    in_free_slot  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_BLOCK_COUNT;
    cfg_wdata     = '0;
    errors        = 0;
    hold_req      = 0;
    calm          = 1'b0;
    burst         = 1'b0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    model_count = COUNT_RESET;
    model_size  = SIZE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        drain();
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].wdata);
      end else begin
        offer(DIR_ROWS[i].op, DIR_ROWS[i].page, DIR_ROWS[i].slot,
              DIR_ROWS[i].kind == ROW_KNOWN, DIR_ROWS[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph % 8)
        0: new_count = 11'd1;
        1: new_count = 11'd2047;
        2: new_count = 11'd1024;
        3: new_count = 11'd0;
        4: new_count = COUNT_W'($urandom_range(2, 128));
        5: new_count = COUNT_W'($urandom_range(129, 1023));
        6: new_count = (ph < 8) ? 11'd64 : 11'd65;
        default: new_count = COUNT_W'($urandom_range(0, 2047));
      endcase
      case (ph % 5)
        0: new_size = 16'd0;
        1: new_size = 16'hFFFF;
        2: new_size = 16'd1;
        3: new_size = SIZE_W'($urandom);
        default: new_size = 16'd64;
      endcase
      junk = (CFG_DATA_W - COUNT_W)'($urandom);
      write_reg(REG_BLOCK_COUNT, {junk, new_count});
      write_reg(REG_BLOCK_SIZE, new_size);
      calm = (ph % 7 == 3);
      burst = calm;
      if (ph == 2) begin
        hold_req = LONG_HOLD;
        burst = 1'b1;
      end
      alloc_pct = (ph % 8 == 4) ? 75 : $urandom_range(30, 90);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
        lim = usable_slots();
        pick = $urandom_range(0, 99);
        if (lim == 0 || pick < 15) begin
          slot = SLOT_W'($urandom);
        end else if (pick < 55) begin
          slot = SLOT_W'($urandom_range(0, lim - 1));
        end else begin
          from = $urandom_range(0, lim - 1);
          slot = SLOT_W'(from);
          for (int unsigned s = 0; s < lim; s++) begin
            if (slot_used[(from + s) % lim]) begin
              slot = SLOT_W'((from + s) % lim);
              break;
            end
          end
        end
        offer(op, PAGE_W'($urandom_range(0, 15)), slot, 1'b0, NO_RESULT);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d allocations, %0d pool-full answers, %0d frees and %0d",
             n_alloc_ok, n_full, n_free_ok, n_range);
    $display("out-of-range frees across %0d register writes.", n_settings);
    if (errors == 0) begin
      $display("[paged_bitmap_block_allocator] OK");
    end else begin
      $display("[paged_bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
